// ===== design/veda_pkg.sv =====
// ----------------------------------------------------------------------------
// veda_pkg
// Shared constants, request codes and types of the voxel energy-deposit
// accumulator.
// ----------------------------------------------------------------------------
package veda_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;

  localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                              : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int CELL_W  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int GRID_W  = CELL_W + 1;
  localparam int LIN_W   = 3 * CELL_W;

  localparam int STORE_DEPTH = 262144;
  localparam int ADDR_W      = 18;
  localparam int BIG_W       = ((LIN_W > ADDR_W) ? LIN_W : ADDR_W) + 1;

  localparam int POS_W    = 32;
  localparam int REG_W    = 31;
  localparam int ENERGY_W = 32;
  localparam int TOTAL_W  = 48;
  localparam int COUNT_W  = 32;
  localparam int OFF_W    = 33;
  localparam int DIV_W    = REG_W + CELL_W;
  localparam int LIMIT_W  = REG_W + GRID_W;
  localparam int STEP_W   = $clog2(CELL_W + 1);

  localparam int CFG_IDX_W = 3;
  localparam int S_DATA_W  = 152;
  localparam int M_DATA_W  = 104;

  localparam logic [1:0] FUNC_HIT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EVENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Z = 3'd5;

  localparam logic [REG_W-1:0]   HALF_RESET  = 31'd8192;
  localparam logic [REG_W-1:0]   PITCH_RESET = 31'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic              done;
    logic              fail;
    logic [CELL_W-1:0] coord;
  } axis_res_t;

endpackage

// ===== design/veda_ram.sv =====
// ----------------------------------------------------------------------------
// veda_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module veda_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/veda_axis.sv =====
// ----------------------------------------------------------------------------
// veda_axis
// One axis of the position-to-voxel mapping: offsets the position by the
// half extent, checks the grid bounds and divides by the pitch, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module veda_axis (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [veda_pkg::POS_W-1:0] pos,
  input  logic [veda_pkg::REG_W-1:0]       half,
  input  logic [veda_pkg::REG_W-1:0]       pitch,
  input  logic [veda_pkg::GRID_W-1:0]      grid,
  output veda_pkg::axis_res_t              res
);

  typedef enum logic [1:0] {A_IDLE, A_CHECK, A_DIV, A_DONE} axis_state_t;

  axis_state_t                     state;
  logic signed [veda_pkg::OFF_W-1:0] off;
  logic [veda_pkg::LIMIT_W-1:0]    limit;
  logic [veda_pkg::POS_W-1:0]      rem;
  logic [veda_pkg::DIV_W-1:0]      div;
  logic [veda_pkg::STEP_W-1:0]     cnt;
  logic [veda_pkg::CELL_W-1:0]     coord;
  logic [veda_pkg::CELL_W-1:0]     coord_next;
  logic                            fail;
  logic                            ge;

  assign ge = veda_pkg::DIV_W'(rem) >= div;

  always_comb begin
    coord_next    = coord << 1;
    coord_next[0] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            off   <= veda_pkg::OFF_W'(pos) + $signed({2'b00, half});
            limit <= veda_pkg::LIMIT_W'(pitch) * veda_pkg::LIMIT_W'(grid);
            state <= A_CHECK;
          end
        end
        A_CHECK: begin
          fail  <= off[veda_pkg::OFF_W-1] || (pitch == '0) ||
                   (veda_pkg::LIMIT_W'(off[veda_pkg::POS_W-1:0]) >= limit);
          rem   <= off[veda_pkg::POS_W-1:0];
          div   <= veda_pkg::DIV_W'(pitch) << (veda_pkg::CELL_W - 1);
          cnt   <= veda_pkg::STEP_W'(veda_pkg::CELL_W - 1);
          coord <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          if (ge) begin
            rem <= rem - div[veda_pkg::POS_W-1:0];
          end
          div   <= div >> 1;
          coord <= coord_next;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= A_DONE;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign res.done  = (state == A_DONE);
  assign res.fail  = fail;
  assign res.coord = coord;

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    res.done |-> $past(state) == A_DIV)
    else $error("axis result flagged without a finished division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (state == A_IDLE && start) |=> state == A_CHECK)
    else $error("axis did not begin on start");

  a_rem_below_pitch: assert property (@(posedge clk) disable iff (rst)
    (state == A_DONE && !fail) |-> veda_pkg::REG_W'(rem) < pitch || rem[veda_pkg::POS_W-1])
    else $error("division remainder not below pitch");

endmodule

// ===== design/voxel_energy_deposit_accumulator.sv =====
// ----------------------------------------------------------------------------
// voxel_energy_deposit_accumulator
// Scores energy-deposit hits into a 64x64x64 voxel dose store.
// ----------------------------------------------------------------------------
// The block handles one request at a time. For a hit request the three axes
// are mapped in parallel by restoring dividers that produce one quotient bit
// per cycle, then the voxel index is formed, the dose store is read and the
// saturated sum is written back. A read request reads the dose store, and an
// end-of-event or no-op request goes straight to its result. A hit that falls
// outside the grid finishes early with out_of_range set. The next request is
// accepted from the cycle after a result is posted. After reset the dose
// store is cleared one entry per cycle, during which no request is accepted;
// configuration writes are taken at all times. A finished result waits in an
// output register, so the next request is accepted meanwhile.
module voxel_energy_deposit_accumulator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [veda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [veda_pkg::REG_W-1:0]           cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], energy[127:96],
  // read_index[145:128], zero fill[151:146]
  input  logic [veda_pkg::S_DATA_W-1:0]        s_tdata,
  // func[1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // voxel_index[17:0], voxel_total[65:18], event_count[97:66],
  // zero fill[103:98]
  output logic [veda_pkg::M_DATA_W-1:0]        m_tdata,
  // out_of_range[0]
  output logic [0:0]                           m_tuser
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_AXIS, S_IDX1, S_IDX2, S_READ, S_MODIFY, S_DONE
  } state_t;

  state_t                          state;
  logic [veda_pkg::REG_W-1:0]      half_x, half_y, half_z;
  logic [veda_pkg::REG_W-1:0]      pitch_x, pitch_y, pitch_z;
  logic [1:0]                      func;
  logic [veda_pkg::ENERGY_W-1:0]   energy;
  logic [veda_pkg::CELL_W-1:0]     cx, cy, cz;
  logic [veda_pkg::LIN_W-1:0]      idx_t;
  logic [veda_pkg::ADDR_W-1:0]     addr;
  logic [veda_pkg::ADDR_W-1:0]     clear_addr;
  logic [veda_pkg::TOTAL_W-1:0]    total;
  logic                            oor;
  logic [veda_pkg::COUNT_W-1:0]    event_counter;
  logic [veda_pkg::COUNT_W-1:0]    event_counter_next;
  logic [veda_pkg::M_DATA_W-1:0]   m_tdata_next;

  logic                            accept;
  logic                            axis_start;
  logic                            out_free;
  logic [veda_pkg::LIN_W-1:0]      lin;
  logic [veda_pkg::TOTAL_W:0]      sum;
  logic                            ram_we;
  logic [veda_pkg::ADDR_W-1:0]     ram_waddr;
  logic [veda_pkg::TOTAL_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [veda_pkg::TOTAL_W-1:0]    ram_rdata;

  veda_pkg::axis_res_t             ax_res, ay_res, az_res;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign axis_start = accept && (s_tuser == veda_pkg::FUNC_HIT);
  assign out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_x  <= veda_pkg::HALF_RESET;
      half_y  <= veda_pkg::HALF_RESET;
      half_z  <= veda_pkg::HALF_RESET;
      pitch_x <= veda_pkg::PITCH_RESET;
      pitch_y <= veda_pkg::PITCH_RESET;
      pitch_z <= veda_pkg::PITCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        veda_pkg::REG_HALF_X:  half_x  <= cfg_data;
        veda_pkg::REG_HALF_Y:  half_y  <= cfg_data;
        veda_pkg::REG_HALF_Z:  half_z  <= cfg_data;
        veda_pkg::REG_PITCH_X: pitch_x <= cfg_data;
        veda_pkg::REG_PITCH_Y: pitch_y <= cfg_data;
        veda_pkg::REG_PITCH_Z: pitch_z <= cfg_data;
        default: ;
      endcase
    end
  end

  veda_axis u_axis_x (
    .clk   (clk),
    .rst   (rst),
    .start (axis_start),
    .pos   ($signed(s_tdata[31:0])),
    .half  (half_x),
    .pitch (pitch_x),
    .grid  (veda_pkg::GRID_W'(veda_pkg::GRID_X)),
    .res   (ax_res)
  );

  veda_axis u_axis_y (
    .clk   (clk),
    .rst   (rst),
    .start (axis_start),
    .pos   ($signed(s_tdata[63:32])),
    .half  (half_y),
    .pitch (pitch_y),
    .grid  (veda_pkg::GRID_W'(veda_pkg::GRID_Y)),
    .res   (ay_res)
  );

  veda_axis u_axis_z (
    .clk   (clk),
    .rst   (rst),
    .start (axis_start),
    .pos   ($signed(s_tdata[95:64])),
    .half  (half_z),
    .pitch (pitch_z),
    .grid  (veda_pkg::GRID_W'(veda_pkg::GRID_Z)),
    .res   (az_res)
  );

  assign lin = idx_t * veda_pkg::LIN_W'(veda_pkg::GRID_Z) + veda_pkg::LIN_W'(cz);
  assign sum = {1'b0, ram_rdata} + (veda_pkg::TOTAL_W + 1)'(energy);
  assign event_counter_next = event_counter + 1'b1;

  always_comb begin
    m_tdata_next        = '0;
    m_tdata_next[97:66] = (func == veda_pkg::FUNC_EVENT) ? event_counter_next
                                                         : event_counter;
    if ((func == veda_pkg::FUNC_HIT && !oor) || func == veda_pkg::FUNC_READ) begin
      m_tdata_next[17:0]  = addr;
      m_tdata_next[65:18] = total;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = total;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else if (state == S_DONE && out_free && func == veda_pkg::FUNC_HIT && !oor) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state == S_READ);

  veda_ram #(
    .WIDTH (veda_pkg::TOTAL_W),
    .DEPTH (veda_pkg::STORE_DEPTH)
  ) u_dose_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clear_addr    <= '0;
      event_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == veda_pkg::ADDR_W'(veda_pkg::STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func   <= s_tuser;
            energy <= s_tdata[127:96];
            addr   <= s_tdata[145:128];
            oor    <= 1'b0;
            case (s_tuser)
              veda_pkg::FUNC_HIT:  state <= S_AXIS;
              veda_pkg::FUNC_READ: state <= S_READ;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_AXIS: begin
          if (ax_res.done) begin
            cx <= ax_res.coord;
            cy <= ay_res.coord;
            cz <= az_res.coord;
            if (ax_res.fail || ay_res.fail || az_res.fail) begin
              oor   <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_IDX1;
            end
          end
        end
        S_IDX1: begin
          idx_t <= veda_pkg::LIN_W'(cx) * veda_pkg::LIN_W'(veda_pkg::GRID_Y) +
                   veda_pkg::LIN_W'(cy);
          state <= S_IDX2;
        end
        S_IDX2: begin
          addr <= veda_pkg::ADDR_W'(lin);
          if (veda_pkg::BIG_W'(lin) >= veda_pkg::BIG_W'(veda_pkg::STORE_DEPTH)) begin
            oor   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          if (func == veda_pkg::FUNC_HIT) begin
            total <= sum[veda_pkg::TOTAL_W] ? veda_pkg::TOTAL_MAX
                                            : sum[veda_pkg::TOTAL_W-1:0];
          end else begin
            total <= ram_rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tuser[0] <= oor;
            m_tdata    <= m_tdata_next;
            if (func == veda_pkg::FUNC_EVENT) begin
              event_counter <= event_counter_next;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request accepted while one is in flight");

  a_axes_together: assert property (@(posedge clk) disable iff (rst)
    ax_res.done |-> ay_res.done && az_res.done)
    else $error("axis results out of step");

  a_oor_zero_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[65:0] == '0))
    else $error("dropped hit reports a voxel or a total");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || (state == S_DONE && !oor)))
    else $error("dose store written outside clear or write-back");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voxel energy-deposit accumulator. Hit, read,
// end-of-event and no-op requests are streamed in and each result is
// compared field by field with a behavioral scoring model kept here,
// covering grid edges, register extremes, heavy accumulation on one voxel
// and randomized traffic with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int GRID_DIM [3] = '{veda_pkg::GRID_X, veda_pkg::GRID_Y, veda_pkg::GRID_Z};
  localparam logic [veda_pkg::CFG_IDX_W-1:0] HALF_REG [3] =
    '{veda_pkg::REG_HALF_X, veda_pkg::REG_HALF_Y, veda_pkg::REG_HALF_Z};
  localparam logic [veda_pkg::CFG_IDX_W-1:0] PITCH_REG [3] =
    '{veda_pkg::REG_PITCH_X, veda_pkg::REG_PITCH_Y, veda_pkg::REG_PITCH_Z};
  localparam logic [veda_pkg::REG_W-1:0] REG_MAX = {veda_pkg::REG_W{1'b1}};

  typedef struct packed {
    logic [veda_pkg::ADDR_W-1:0]  voxel_index;
    logic [veda_pkg::TOTAL_W-1:0] voxel_total;
    logic                         out_of_range;
    logic [veda_pkg::COUNT_W-1:0] event_count;
  } voxel_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [veda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [veda_pkg::REG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [veda_pkg::S_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [veda_pkg::M_DATA_W-1:0]  m_tdata;
  logic [0:0]                     m_tuser;

  logic [veda_pkg::REG_W-1:0]   grid_half [3];
  logic [veda_pkg::REG_W-1:0]   grid_pitch [3];
  logic [veda_pkg::TOTAL_W-1:0] dose_mem [int];
  logic [veda_pkg::COUNT_W-1:0] events_done = '0;
  logic [veda_pkg::ADDR_W-1:0]  recent_voxels [$];
  voxel_result_t                pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int n_hits = 0;
  int n_dropped = 0;
  int n_reads = 0;
  int n_events = 0;
  int n_nops = 0;
  int n_settings = 0;

  voxel_energy_deposit_accumulator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [veda_pkg::TOTAL_W-1:0] dose_of(int idx);
    return dose_mem.exists(idx) ? dose_mem[idx] : '0;
  endfunction

  function automatic bit map_axis(logic [31:0] pos, logic [veda_pkg::REG_W-1:0] half,
                                  logic [veda_pkg::REG_W-1:0] pitch, int dim,
                                  output longint coord);
    longint off;
    off = longint'($signed(pos)) + longint'(half);
    coord = 0;
    if (off < 0 || pitch == 0) begin
      return 1'b0;
    end
    coord = off / longint'(pitch);
    return coord < dim;
  endfunction

  // Updates the dose store and event counter and returns the expected result.
  function automatic voxel_result_t score_request(logic [1:0] f, logic [31:0] px,
                                                  logic [31:0] py, logic [31:0] pz,
                                                  logic [31:0] en,
                                                  logic [veda_pkg::ADDR_W-1:0] ridx);
    voxel_result_t r;
    longint cx, cy, cz, lin;
    bit in_grid;
    logic [veda_pkg::TOTAL_W:0] sum;
    r = '0;
    case (f)
      veda_pkg::FUNC_HIT: begin
        n_hits++;
        in_grid = map_axis(px, grid_half[0], grid_pitch[0], veda_pkg::GRID_X, cx)
               && map_axis(py, grid_half[1], grid_pitch[1], veda_pkg::GRID_Y, cy)
               && map_axis(pz, grid_half[2], grid_pitch[2], veda_pkg::GRID_Z, cz);
        lin = 0;
        if (in_grid) begin
          lin = (cx * veda_pkg::GRID_Y + cy) * veda_pkg::GRID_Z + cz;
          if (lin >= veda_pkg::STORE_DEPTH) in_grid = 1'b0;
        end
        if (in_grid) begin
          sum = {1'b0, dose_of(int'(lin))} + en;
          r.voxel_total = (sum > veda_pkg::TOTAL_MAX) ? veda_pkg::TOTAL_MAX
                                                      : sum[veda_pkg::TOTAL_W-1:0];
          r.voxel_index = lin[veda_pkg::ADDR_W-1:0];
          dose_mem[int'(lin)] = r.voxel_total;
          recent_voxels.insert(recent_voxels.size(), r.voxel_index);
          if (recent_voxels.size() > 64) void'(recent_voxels.pop_front());
        end else begin
          r.out_of_range = 1'b1;
          n_dropped++;
        end
      end
      veda_pkg::FUNC_READ: begin
        n_reads++;
        r.voxel_index = ridx;
        r.voxel_total = dose_of(int'(ridx));
      end
      veda_pkg::FUNC_EVENT: begin
        n_events++;
        events_done = events_done + 1'b1;
      end
      default: begin
        n_nops++;
      end
    endcase
    r.event_count = events_done;
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    voxel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual %h", $time,
                 m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("voxel_index", 64'(want.voxel_index), 64'(m_tdata[17:0]));
        check_field("voxel_total", 64'(want.voxel_total), 64'(m_tdata[65:18]));
        check_field("event_count", 64'(want.event_count), 64'(m_tdata[97:66]));
        check_field("out_of_range", 64'(want.out_of_range), 64'(m_tuser[0]));
      end
    end
  end

  // Presents one request and returns at the falling edge after its acceptance.
  task automatic send_request(logic [1:0] f, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz, logic [31:0] en,
                              logic [veda_pkg::ADDR_W-1:0] ridx);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {6'b0, ridx, en, pz, py, px};
    do @(posedge clk); while (!s_tready);
    pending_results.insert(pending_results.size(), score_request(f, px, py, pz, en, ridx));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_grid(logic [veda_pkg::REG_W-1:0] hx, logic [veda_pkg::REG_W-1:0] hy,
                          logic [veda_pkg::REG_W-1:0] hz, logic [veda_pkg::REG_W-1:0] px,
                          logic [veda_pkg::REG_W-1:0] py, logic [veda_pkg::REG_W-1:0] pz);
    logic [veda_pkg::REG_W-1:0] halves [3];
    logic [veda_pkg::REG_W-1:0] pitches [3];
    halves = '{hx, hy, hz};
    pitches = '{px, py, pz};
    for (int a = 0; a < 3; a++) begin
      cfg_we <= 1'b1;
      cfg_index <= HALF_REG[a];
      cfg_data <= halves[a];
      grid_half[a] = halves[a];
      @(negedge clk);
      cfg_index <= PITCH_REG[a];
      cfg_data <= pitches[a];
      grid_pitch[a] = pitches[a];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [31:0] to_pos(longint v);
    if (v < -64'sd2147483648) return 32'h8000_0000;
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pos_in_cell(int a, int coord);
    longint v;
    v = -longint'(grid_half[a]) + longint'(coord) * longint'(grid_pitch[a]);
    if (grid_pitch[a] != 0) v += longint'($urandom % grid_pitch[a]);
    return to_pos(v);
  endfunction

  function automatic logic [31:0] pos_outside(int a);
    longint v;
    if ($urandom_range(1)) begin
      v = -longint'(grid_half[a]) - 1 - $urandom_range(3);
    end else begin
      v = -longint'(grid_half[a]) + longint'(GRID_DIM[a]) * longint'(grid_pitch[a])
          + $urandom_range(3);
    end
    return to_pos(v);
  endfunction

  task automatic hit_cell(int cx, int cy, int cz, logic [31:0] en);
    send_request(veda_pkg::FUNC_HIT, pos_in_cell(0, cx), pos_in_cell(1, cy),
                 pos_in_cell(2, cz), en, veda_pkg::ADDR_W'($urandom));
  endtask

  task automatic random_request();
    int pick;
    int edge_axis;
    logic [31:0] p [3];
    logic [31:0] en;
    logic [veda_pkg::ADDR_W-1:0] ridx;
    logic [1:0] f;
    pick = $urandom_range(99);
    en = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535);
    ridx = veda_pkg::ADDR_W'($urandom);
    for (int a = 0; a < 3; a++) p[a] = $urandom;
    f = veda_pkg::FUNC_HIT;
    if (pick < 60) begin
      for (int a = 0; a < 3; a++) p[a] = pos_in_cell(a, $urandom_range(GRID_DIM[a] - 1));
    end else if (pick < 68) begin
      edge_axis = $urandom_range(2);
      for (int a = 0; a < 3; a++) begin
        p[a] = (a == edge_axis) ? pos_outside(a) : pos_in_cell(a, $urandom_range(GRID_DIM[a] - 1));
      end
    end else if (pick < 73) begin
      f = veda_pkg::FUNC_HIT;
    end else if (pick < 88) begin
      f = veda_pkg::FUNC_READ;
      if (recent_voxels.size() != 0 && $urandom_range(3) != 0) begin
        ridx = recent_voxels[$urandom_range(recent_voxels.size() - 1)];
      end
    end else if (pick < 96) begin
      f = veda_pkg::FUNC_EVENT;
    end else begin
      f = FUNC_NOP;
    end
    send_request(f, p[0], p[1], p[2], en, ridx);
  endtask

  task automatic test_grid_edges();
    send_request(veda_pkg::FUNC_HIT, -32'sd8192, -32'sd8192, -32'sd8192, 32'd0, '0);
    send_request(veda_pkg::FUNC_HIT, -32'sd8192, -32'sd8192, -32'sd8192, 32'hFFFF_FFFF, '0);
    send_request(veda_pkg::FUNC_HIT, -32'sd8192, -32'sd8192, -32'sd8192, 32'd1, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd8191, 32'sd8191, 32'sd8191, 32'h1234_5678, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd8192, 32'sd0, 32'sd0, 32'd5, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, -32'sd8193, 32'sd0, 32'd5, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, 32'sd8192, 32'd5, '0);
    send_request(veda_pkg::FUNC_HIT, 32'h8000_0000, 32'sd0, 32'sd0, 32'd5, '0);
    send_request(veda_pkg::FUNC_HIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, 32'sd0, 32'hDEAD_BEEF, '0);
    send_request(veda_pkg::FUNC_HIT, -32'sd1, 32'sd255, 32'sd256, 32'd77, '0);
    send_request(veda_pkg::FUNC_READ, '1, '1, '1, '1, 18'd0);
    send_request(veda_pkg::FUNC_READ, '0, '0, '0, '0, 18'h3FFFF);
    send_request(veda_pkg::FUNC_READ, '0, '0, '0, '0, 18'h2AAAA);
    send_request(veda_pkg::FUNC_READ, '0, '0, '0, '0, 18'd133152);
    send_request(veda_pkg::FUNC_EVENT, '1, '1, '1, '1, '1);
    send_request(veda_pkg::FUNC_EVENT, '0, '0, '0, '0, '0);
    send_request(FUNC_NOP, '1, '1, '1, '1, '1);
    send_request(FUNC_NOP, '0, '0, '0, '0, 18'h15555);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_grid('0, '0, '0, 31'd1, 31'd1, 31'd1);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, 32'sd0, 32'd3, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd63, 32'sd63, 32'sd63, 32'd4, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd64, 32'sd0, 32'sd0, 32'd4, '0);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, -32'sd1, 32'd4, '0);
    wait_idle();
    set_grid(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, 32'sd0, 32'd6, '0);
    send_request(veda_pkg::FUNC_HIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd7, '0);
    send_request(veda_pkg::FUNC_HIT, 32'h8000_0000, 32'sd0, 32'sd0, 32'd7, '0);
    wait_idle();
    // A zero pitch on one axis must drop every hit.
    set_grid(veda_pkg::HALF_RESET, veda_pkg::HALF_RESET, veda_pkg::HALF_RESET, '0,
             veda_pkg::PITCH_RESET, veda_pkg::PITCH_RESET);
    send_request(veda_pkg::FUNC_HIT, 32'sd0, 32'sd0, 32'sd0, 32'd9, '0);
    send_request(veda_pkg::FUNC_HIT, -32'sd8192, 32'sd0, 32'sd0, 32'd9, '0);
    wait_idle();
    set_grid(veda_pkg::HALF_RESET, veda_pkg::HALF_RESET, veda_pkg::HALF_RESET,
             veda_pkg::PITCH_RESET, veda_pkg::PITCH_RESET, veda_pkg::PITCH_RESET);
  endtask

  // Piles large deposits onto one voxel and reads the total back.
  task automatic test_heavy_voxel();
    logic [31:0] tail [5];
    tail = '{32'd65534, 32'd1, 32'd0, 32'd1, 32'hFFFF_FFFF};
    for (int i = 0; i < 12; i++) hit_cell(31, 17, 46, 32'hFFFF_FFFF);
    foreach (tail[i]) hit_cell(31, 17, 46, tail[i]);
    send_request(veda_pkg::FUNC_READ, '0, '0, '0, '0,
                 veda_pkg::ADDR_W'((31 * veda_pkg::GRID_Y + 17) * veda_pkg::GRID_Z + 46));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count, bit drain_midway);
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (drain_midway && i == count / 2) wait_idle();
      random_request();
    end
  endtask

  initial begin
    logic [veda_pkg::REG_W-1:0] p [3];
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    set_grid(veda_pkg::HALF_RESET, veda_pkg::HALF_RESET, veda_pkg::HALF_RESET,
             veda_pkg::PITCH_RESET, veda_pkg::PITCH_RESET, veda_pkg::PITCH_RESET);
    test_grid_edges();
    test_register_extremes();
    test_heavy_voxel();
    test_random_traffic(11, 45, 200, 1'b0);
    wait_idle();
    set_grid(veda_pkg::REG_W'($urandom_range(20000)), veda_pkg::REG_W'($urandom_range(20000)),
             veda_pkg::REG_W'($urandom_range(20000)), veda_pkg::REG_W'($urandom_range(1000, 1)),
             veda_pkg::REG_W'($urandom_range(1000, 1)),
             veda_pkg::REG_W'($urandom_range(1000, 1)));
    test_random_traffic(45, 11, 200, 1'b1);
    wait_idle();
    for (int a = 0; a < 3; a++) p[a] = veda_pkg::REG_W'($urandom_range(1 << 26, 1 << 25));
    set_grid(veda_pkg::REG_W'(p[0] * 32 + $urandom_range(p[0])),
             veda_pkg::REG_W'(p[1] * 32 + $urandom_range(p[1])),
             veda_pkg::REG_W'(p[2] * 32 + $urandom_range(p[2])), p[0], p[1], p[2]);
    test_random_traffic(0, 0, 200, 1'b0);
    wait_idle();
    repeat (30) @(negedge clk);
    $display("Covered %0d hits (%0d dropped outside the grid), %0d reads, %0d events,",
             n_hits, n_dropped, n_reads, n_events);
    $display("%0d no-op requests and %0d register settings; %0d field mismatches.",
             n_nops, n_settings, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/veda_pkg.sv
design/veda_ram.sv
design/veda_axis.sv
design/voxel_energy_deposit_accumulator.sv
test/tb.sv
